// ----- hw/rtl/pixel_tone_enhance_unit_assert.svh -----
// Assertion macros for the pixel tone enhance unit.
// Used by the checker; needs nothing else.
`ifndef PIXEL_TONE_ENHANCE_UNIT_ASSERT_SVH
`define PIXEL_TONE_ENHANCE_UNIT_ASSERT_SVH

// Consequent must follow whenever the antecedent holds.
`define PTE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("pixel tone enhance: implication violated");

// Expression must never be true out of reset.
`define PTE_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("pixel tone enhance: forbidden condition seen");

`endif

// ----- hw/rtl/pte_pkg.sv -----
// Package for the pixel tone enhance unit: constants, register codes and
// fixed point helpers. Depends on nothing.
package pte_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic signed [17:0] LUM_R       = 18'sd13933;
  localparam logic signed [17:0] LUM_G       = 18'sd46871;
  localparam logic signed [17:0] LUM_B       = 18'sd4732;
  localparam logic signed [17:0] K_SHADOW    = 18'sd22282;
  localparam logic signed [17:0] K_HIGHLIGHT = 18'sd19661;
  localparam logic signed [17:0] K_WHITES    = 18'sd36045;
  localparam logic signed [17:0] K_CONTRAST  = 18'sd36045;
  localparam logic signed [17:0] K_VIBRANCE  = 18'sd55706;

  localparam logic [15:0] GAIN_RESET  = 16'd4096;
  localparam logic [12:0] BLEND_RESET = 13'd4096;

  typedef enum logic [2:0] {
    REG_GAIN,
    REG_HIGH,
    REG_SHAD,
    REG_WHITE,
    REG_CONTR,
    REG_VIB,
    REG_BLEND
  } pte_reg_t;

  // Right shift that rounds half away from zero.
  function automatic logic signed [63:0] rsh(input logic signed [63:0] v,
                                             input int unsigned s);
    logic [63:0] m;
    logic [63:0] half;
    half = 64'd1 << (s - 1);
    m = v[63] ? (64'd0 - 64'(v)) : 64'(v);
    m = (m + half) >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  // Saturate to the range zero to one.
  function automatic logic signed [63:0] clampfx(input logic signed [63:0] v,
                                                 input int unsigned f);
    logic signed [63:0] one;
    one = 64'sd1 <<< f;
    if (v < 0) return 64'sd0;
    if (v > one) return one;
    return v;
  endfunction

endpackage

// ----- hw/rtl/pte_tone.sv -----
// Tone stages: normalize, exposure, shadow/highlight lifts, whites, contrast.
// Nine register stages. Depends on pte_pkg.
module pte_tone #(
  parameter int FRAC_BITS = pte_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [7:0]                  red,
  input  logic [7:0]                  green,
  input  logic [7:0]                  blue,
  input  logic [7:0]                  alpha,
  input  logic                        last,
  input  logic [15:0]                 gain,
  input  logic signed [14:0]          shadows,
  input  logic signed [14:0]          highlights,
  input  logic signed [14:0]          whites,
  input  logic signed [FRAC_BITS+3:0] contrast_factor,
  output logic                        out_valid,
  output logic [FRAC_BITS:0]          tone [3],
  output logic [FRAC_BITS:0]          orig [3],
  output logic [7:0]                  alpha_out,
  output logic                        last_out
);
  import pte_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int VW = F + 10;
  localparam logic signed [63:0] ONE  = 64'sd1 <<< F;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (F - 1);

  logic [F:0] otab [256];
  for (genvar b = 0; b < 256; b++) begin : g_otab
    assign otab[b] = (F + 1)'(((64'(b) << (F + 1)) + 64'd255) / 64'd510);
  end

  logic [9:1]             val_q;
  logic [9:1]             last_q;
  logic [7:0]             alpha_q [1:9];
  logic [F:0]             o_q [1:9][3];
  logic signed [VW-1:0]   c_q [1:5][3];
  logic [F:0]             l_q;
  logic [F:0]             sm_q;
  logic [F:0]             hm_q;
  logic signed [F+5:0]    ps_q;
  logic signed [F+5:0]    ph_q;
  logic signed [F+5:0]    pw_q;
  logic signed [VW-1:0]   lift_q;
  logic signed [F+5:0]    wh5_q;
  logic signed [F+5:0]    wh6_q;
  logic signed [VW-1:0]   ca_q [3];
  logic signed [VW-1:0]   ca7_q [3];
  logic signed [VW-1:0]   t_q [3];
  logic signed [VW-1:0]   cb_q [3];
  logic [F:0]             cc_q [3];

  logic [7:0]             px [3];
  logic signed [F+18:0]   prod1 [3];
  logic signed [VW+19:0]  lsum;
  logic [F:0]             inv_l;
  logic [2*F+1:0]         sq_s;
  logic [2*F+1:0]         sq_h;
  logic signed [F+16:0]   ps;
  logic signed [F+16:0]   ph;
  logic signed [F+16:0]   pw;
  logic signed [F+23:0]   ls;
  logic signed [F+23:0]   lh;
  logic signed [VW:0]     oc [3];
  logic signed [VW+F+6:0] wt [3];
  logic signed [VW+17:0]  tk [3];
  logic signed [VW:0]     dc [3];
  logic signed [VW+F+4:0] pc [3];

  always_comb begin
    px[0] = red;
    px[1] = green;
    px[2] = blue;
    lsum = LUM_R * c_q[1][0] + LUM_G * c_q[1][1] + LUM_B * c_q[1][2];
    inv_l = (F + 1)'(ONE) - l_q;
    sq_s = inv_l * inv_l;
    sq_h = l_q * l_q;
    ps = shadows * $signed({1'b0, sm_q});
    ph = highlights * $signed({1'b0, hm_q});
    pw = whites * $signed({1'b0, hm_q});
    ls = ps_q * K_SHADOW;
    lh = ph_q * K_HIGHLIGHT;
    for (int i = 0; i < 3; i++) begin
      prod1[i] = $signed({1'b0, otab[px[i]]}) * $signed({1'b0, gain});
      oc[i] = (VW + 1)'(ONE) - ca_q[i];
      wt[i] = wh6_q * oc[i];
      tk[i] = t_q[i] * K_WHITES;
      dc[i] = cb_q[i] - (VW + 1)'(HALF);
      pc[i] = dc[i] * contrast_factor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val_q <= '0;
    end else begin
      val_q <= {val_q[8:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    last_q <= {last_q[8:1], last};
    alpha_q[1] <= alpha;
    for (int k = 2; k <= 9; k++) alpha_q[k] <= alpha_q[k-1];
    l_q <= (F + 1)'(clampfx(rsh(64'(lsum), 16), F));
    sm_q <= (F + 1)'(rsh(64'(sq_s), F));
    hm_q <= (F + 1)'(rsh(64'(sq_h), F));
    ps_q <= (F + 6)'(rsh(64'(ps), 12));
    ph_q <= (F + 6)'(rsh(64'(ph), 12));
    pw_q <= (F + 6)'(rsh(64'(pw), 12));
    lift_q <= VW'(rsh(64'(ls), 16) + rsh(64'(lh), 16));
    wh5_q <= pw_q;
    wh6_q <= wh5_q;
    for (int i = 0; i < 3; i++) begin
      o_q[1][i] <= otab[px[i]];
      for (int k = 2; k <= 9; k++) o_q[k][i] <= o_q[k-1][i];
      c_q[1][i] <= VW'(rsh(64'(prod1[i]), 12));
      for (int k = 2; k <= 5; k++) c_q[k][i] <= c_q[k-1][i];
      ca_q[i] <= c_q[5][i] + lift_q;
      ca7_q[i] <= ca_q[i];
      t_q[i] <= VW'(rsh(64'(wt[i]), F));
      cb_q[i] <= ca7_q[i] + VW'(rsh(64'(tk[i]), 16));
      cc_q[i] <= (F + 1)'(clampfx(HALF + rsh(64'(pc[i]), F), F));
    end
  end

  assign out_valid = val_q[9];
  assign alpha_out = alpha_q[9];
  assign last_out  = last_q[9];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tone[i] = cc_q[i];
      orig[i] = o_q[9][i];
    end
  end

endmodule

// ----- hw/rtl/pte_color.sv -----
// Color stages: vibrance about luma, blend with the original, byte rounding.
// Six register stages. Depends on pte_pkg.
module pte_color #(
  parameter int FRAC_BITS = pte_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [FRAC_BITS:0] tone [3],
  input  logic [FRAC_BITS:0] orig [3],
  input  logic [7:0]         alpha,
  input  logic               last,
  input  logic signed [31:0] vib_k,
  input  logic [12:0]        blend,
  output logic               out_valid,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [7:0]         alpha_out,
  output logic               last_out
);
  import pte_pkg::*;

  localparam int F = FRAC_BITS;
  localparam logic signed [63:0] ONE  = 64'sd1 <<< F;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (F - 1);

  logic [6:1]             val_q;
  logic [6:1]             last_q;
  logic [7:0]             alpha_q [1:6];
  logic [F:0]             c_q [1:3][3];
  logic [F:0]             o_q [1:4][3];
  logic signed [F+20:0]   ys_q;
  logic [F:0]             s_q;
  logic [F:0]             y2_q;
  logic [F:0]             y3_q;
  logic signed [F+33:0]   pv_q;
  logic signed [F+3:0]    vf_q;
  logic [F:0]             v_q [3];
  logic [F:0]             w_q [3];
  logic [7:0]             q_q [3];

  logic signed [F+20:0]   ys;
  logic [F:0]             mx;
  logic [F:0]             mn;
  logic [F:0]             inv_s;
  logic signed [F+33:0]   pv;
  logic signed [F+1:0]    d [3];
  logic signed [2*F+5:0]  pd [3];
  logic signed [F+1:0]    e [3];
  logic signed [F+15:0]   pe [3];
  logic [F+8:0]           qw [3];

  always_comb begin
    ys = LUM_R * $signed({1'b0, tone[0]}) + LUM_G * $signed({1'b0, tone[1]})
       + LUM_B * $signed({1'b0, tone[2]});
    mx = tone[0];
    mn = tone[0];
    for (int i = 1; i < 3; i++) begin
      if (tone[i] > mx) mx = tone[i];
      if (tone[i] < mn) mn = tone[i];
    end
    inv_s = (F + 1)'(ONE) - s_q;
    pv = vib_k * $signed({1'b0, inv_s});
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed({1'b0, c_q[3][i]}) - $signed({1'b0, y3_q});
      pd[i] = d[i] * vf_q;
      e[i] = $signed({1'b0, v_q[i]}) - $signed({1'b0, o_q[4][i]});
      pe[i] = e[i] * $signed({1'b0, blend});
      qw[i] = w_q[i] * 9'd255 + (F + 9)'(HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val_q <= '0;
    end else begin
      val_q <= {val_q[5:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    last_q <= {last_q[5:1], last};
    alpha_q[1] <= alpha;
    for (int k = 2; k <= 6; k++) alpha_q[k] <= alpha_q[k-1];
    ys_q <= ys;
    s_q <= mx - mn;
    y2_q <= (F + 1)'(rsh(64'(ys_q), 16));
    pv_q <= pv;
    y3_q <= y2_q;
    vf_q <= (F + 4)'(ONE + rsh(64'(pv_q), 28));
    for (int i = 0; i < 3; i++) begin
      c_q[1][i] <= tone[i];
      for (int k = 2; k <= 3; k++) c_q[k][i] <= c_q[k-1][i];
      o_q[1][i] <= orig[i];
      for (int k = 2; k <= 4; k++) o_q[k][i] <= o_q[k-1][i];
      v_q[i] <= (F + 1)'(clampfx(64'($signed({1'b0, y3_q})) + rsh(64'(pd[i]), F), F));
      w_q[i] <= (F + 1)'(clampfx(64'($signed({1'b0, o_q[4][i]})) + rsh(64'(pe[i]), 12),
                                 F));
      q_q[i] <= qw[i][F+7:F];
    end
  end

  assign out_valid = val_q[6];
  assign red       = q_q[0];
  assign green     = q_q[1];
  assign blue      = q_q[2];
  assign alpha_out = alpha_q[6];
  assign last_out  = last_q[6];

endmodule

// ----- hw/rtl/pixel_tone_enhance_unit.sv -----
// Top level of the pixel tone enhance unit: configuration registers and the
// tone and color pipelines. Depends on pte_pkg, pte_tone and pte_color.
//
// Usage: drive a pixel word on red_in, green_in, blue_in, alpha_in and
// pixel_last with start high; it is taken at the clock edge where start is
// high and busy is low. busy stays low, so one pixel may be given every
// cycle. The enhanced word appears on red_out, green_out, blue_out,
// alpha_out and last_out with done high for exactly one cycle, after nine
// stages in the tone pipeline and six in the color pipeline, none chaining
// two multiplies. Throughput is one word per cycle. The receiver cannot
// stall; every word must be taken in the cycle it is shown. Settings are
// to be written through cfg_we, cfg_addr and cfg_data only while no pixel
// is in flight; the block does not enforce this. An index beyond the last
// register is ignored. A synchronous reset empties the pipeline at once
// and restores unity gain, full blend and zero for every other setting.
module pixel_tone_enhance_unit #(
  parameter int FRAC_BITS = pte_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic [7:0]  alpha_in,
  input  logic        pixel_last,
  output logic        done,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic [7:0]  alpha_out,
  output logic        last_out,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_data
);
  import pte_pkg::*;

  localparam int F = FRAC_BITS;
  localparam logic signed [63:0] ONE = 64'sd1 <<< F;

  logic [15:0]        exposure_gain;
  logic signed [14:0] highlights_amount;
  logic signed [14:0] shadows_amount;
  logic signed [14:0] whites_amount;
  logic signed [14:0] contrast_amount;
  logic signed [14:0] vibrance_amount;
  logic [12:0]        blend_intensity;
  logic signed [F+3:0] contrast_factor;
  logic signed [31:0]  vib_k;

  logic signed [32:0] pcf;
  logic signed [32:0] pvk;

  logic        tone_valid;
  logic [F:0]  tone [3];
  logic [F:0]  orig [3];
  logic [7:0]  tone_alpha;
  logic        tone_last;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      exposure_gain     <= GAIN_RESET;
      highlights_amount <= '0;
      shadows_amount    <= '0;
      whites_amount     <= '0;
      contrast_amount   <= '0;
      vibrance_amount   <= '0;
      blend_intensity   <= BLEND_RESET;
    end else if (cfg_we) begin
      unique case (pte_reg_t'(cfg_addr))
        REG_GAIN:  exposure_gain     <= cfg_data;
        REG_HIGH:  highlights_amount <= cfg_data[14:0];
        REG_SHAD:  shadows_amount    <= cfg_data[14:0];
        REG_WHITE: whites_amount     <= cfg_data[14:0];
        REG_CONTR: contrast_amount   <= cfg_data[14:0];
        REG_VIB:   vibrance_amount   <= cfg_data[14:0];
        REG_BLEND: blend_intensity   <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pcf = contrast_amount * K_CONTRAST;
    pvk = vibrance_amount * K_VIBRANCE;
  end

  always_ff @(posedge clk) begin
    contrast_factor <= (F + 4)'(ONE + rsh(64'(pcf) <<< F, 28));
    vib_k <= pvk[31:0];
  end

  pte_tone #(.FRAC_BITS(FRAC_BITS)) u_tone (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (start && !busy),
    .red             (red_in),
    .green           (green_in),
    .blue            (blue_in),
    .alpha           (alpha_in),
    .last            (pixel_last),
    .gain            (exposure_gain),
    .shadows         (shadows_amount),
    .highlights      (highlights_amount),
    .whites          (whites_amount),
    .contrast_factor (contrast_factor),
    .out_valid       (tone_valid),
    .tone            (tone),
    .orig            (orig),
    .alpha_out       (tone_alpha),
    .last_out        (tone_last)
  );

  pte_color #(.FRAC_BITS(FRAC_BITS)) u_color (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tone_valid),
    .tone      (tone),
    .orig      (orig),
    .alpha     (tone_alpha),
    .last      (tone_last),
    .vib_k     (vib_k),
    .blend     (blend_intensity),
    .out_valid (done),
    .red       (red_out),
    .green     (green_out),
    .blue      (blue_out),
    .alpha_out (alpha_out),
    .last_out  (last_out)
  );

endmodule

// ----- hw/rtl/pte_checker.sv -----
// Port-level checker for the pixel tone enhance unit, bound to the top.
// Depends on pixel_tone_enhance_unit_assert.svh.
`include "pixel_tone_enhance_unit_assert.svh"

module pte_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [7:0] alpha_in,
  input logic       pixel_last,
  input logic       done,
  input logic [7:0] alpha_out,
  input logic       last_out
);
  localparam int LAT = 15;

  `PTE_ASSERT_NEVER(busy_never, clk, rst, busy)
  `PTE_ASSERT_IMPL(word_delivered, clk, rst, start && !busy, (##LAT done))
  `PTE_ASSERT_IMPL(word_was_taken, clk, rst, done, ($past(start && !busy, LAT)))
  `PTE_ASSERT_IMPL(side_kept, clk, rst, done,
    (alpha_out == $past(alpha_in, LAT) && last_out == $past(pixel_last, LAT)))

endmodule

bind pixel_tone_enhance_unit pte_checker u_pte_checker (.*);
